[hw/rtl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the ringtone parser: request and response
// payloads, the parser action bundle and the pitch table.
// ----------------------------------------------------------------------------
package rtp_pkg;

   localparam int unsigned PITCH_TABLE_ENTRIES = 49;
   localparam int unsigned PITCH_TABLE_SIZE    = 49;
   localparam int unsigned MS_PER_MINUTE       = 60000;
   localparam int unsigned DIV_WIDTH           = 18;
   localparam int unsigned DIVISOR_WIDTH       = 10;

   localparam logic [1:0] CSR_INIT_LENGTH = 2'd0;
   localparam logic [1:0] CSR_INIT_OCTAVE = 2'd1;
   localparam logic [1:0] CSR_INIT_TEMPO  = 2'd2;
   localparam logic [1:0] CSR_OCT_SHIFT   = 2'd3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       song_start;
   } rtp_req_type;

   typedef struct packed {
      logic [11:0] tone_hz;
      logic [18:0] duration_ms;
      logic        is_rest;
      logic        bad_pitch;
      logic        last;
   } rtp_rsp_type;

   // what one request asks of the sequencer
   typedef struct packed {
      logic        emit;
      logic        last;
      logic        note_valid;
      logic        enter;
      logic        dotted;
      logic        is_rest;
      logic        bad_pitch;
      logic [11:0] tone_hz;
      logic [7:0]  note_divisor;
      logic [9:0]  tempo_divisor;
      logic [17:0] whole_note_ms;
   } rtp_action_type;

   function automatic logic [11:0] pitch_lookup(input logic [5:0] idx);
      logic [11:0] hz;
      case (idx)
         6'd1:  hz = 12'd262;   6'd2:  hz = 12'd277;   6'd3:  hz = 12'd294;
         6'd4:  hz = 12'd311;   6'd5:  hz = 12'd330;   6'd6:  hz = 12'd349;
         6'd7:  hz = 12'd370;   6'd8:  hz = 12'd392;   6'd9:  hz = 12'd415;
         6'd10: hz = 12'd440;   6'd11: hz = 12'd466;   6'd12: hz = 12'd494;
         6'd13: hz = 12'd523;   6'd14: hz = 12'd554;   6'd15: hz = 12'd587;
         6'd16: hz = 12'd622;   6'd17: hz = 12'd659;   6'd18: hz = 12'd698;
         6'd19: hz = 12'd740;   6'd20: hz = 12'd784;   6'd21: hz = 12'd831;
         6'd22: hz = 12'd880;   6'd23: hz = 12'd932;   6'd24: hz = 12'd988;
         6'd25: hz = 12'd1047;  6'd26: hz = 12'd1109;  6'd27: hz = 12'd1175;
         6'd28: hz = 12'd1245;  6'd29: hz = 12'd1319;  6'd30: hz = 12'd1397;
         6'd31: hz = 12'd1480;  6'd32: hz = 12'd1568;  6'd33: hz = 12'd1661;
         6'd34: hz = 12'd1760;  6'd35: hz = 12'd1865;  6'd36: hz = 12'd1976;
         6'd37: hz = 12'd2093;  6'd38: hz = 12'd2217;  6'd39: hz = 12'd2349;
         6'd40: hz = 12'd2489;  6'd41: hz = 12'd2637;  6'd42: hz = 12'd2794;
         6'd43: hz = 12'd2960;  6'd44: hz = 12'd3136;  6'd45: hz = 12'd3322;
         6'd46: hz = 12'd3520;  6'd47: hz = 12'd3729;  6'd48: hz = 12'd3951;
         default: hz = 12'd0;
      endcase
      return hz;
   endfunction

endpackage

[hw/rtl/rtttl_ringtone_parser.sv]
// ----------------------------------------------------------------------------
// rtttl_ringtone_parser
// Ringtone string parser: one byte per request in, one note per response out.
//
// req_valid/req_stall/req_data carry one string byte and the song start flag.
// rsp_valid/rsp_stall/rsp_data carry one note: frequency, duration in ms,
// rest, bad pitch and end-of-song flags. csr_we/csr_index/csr_wdata write the
// initial length, octave, tempo and the octave shift, only while idle; the
// user must keep to this, the block itself does not enforce it. A byte that
// needs no division or response leaves the parser idle, so the next request is
// taken in the following cycle. A header or note end runs the bit-serial
// 18-bit divider, then a header end stores the whole-note length and a note end
// registers its response. End-of-song without a pending note skips the divider.
// The response register is separate from the divider, so a new request is
// taken while an earlier response waits under rsp_stall; a second response
// waits in the sequencer until the register drains, holding req_stall high.
// Reset clears the grammar state, restores the default length 4, octave 6,
// tempo 63 and octave shift -1, and empties the response register.
// ----------------------------------------------------------------------------
module rtttl_ringtone_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtp_pkg::rtp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rtp_pkg::rtp_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_wdata
);
   import rtp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        tempo_job_ff, tempo_job_in;
   logic        dotted_ff, dotted_in;
   rtp_rsp_type note_ff, note_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rtp_rsp_type rsp_data_ff, rsp_data_in;

   rtp_action_type act;
   logic           accept;
   logic           div_start;
   logic           div_done;
   logic [DIV_WIDTH-1:0]     quotient;
   logic [DIV_WIDTH-1:0]     dividend;
   logic [DIVISOR_WIDTH-1:0] divisor;
   logic                     wn_we;
   logic                     out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = accept && (act.enter || (act.emit && act.note_valid));
   assign dividend  = act.enter ? DIV_WIDTH'(MS_PER_MINUTE) : act.whole_note_ms;
   assign divisor   = act.enter ? act.tempo_divisor : {2'b00, act.note_divisor};
   assign wn_we     = div_done && tempo_job_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   rtp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wn_we     (wn_we),
      .wn_value  ({quotient[15:0], 2'b00}),
      .act       (act)
   );

   rtp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      tempo_job_in = tempo_job_ff;
      dotted_in    = dotted_ff;
      note_in      = note_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tempo_job_in        = act.enter;
               dotted_in           = act.dotted;
               note_in.tone_hz     = act.tone_hz;
               note_in.duration_ms = '0;
               note_in.is_rest     = act.is_rest;
               note_in.bad_pitch   = act.bad_pitch;
               note_in.last        = act.last;
               if (div_start) begin
                  state_in = ST_DIV;
               end else if (act.emit) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (tempo_job_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // dotted note adds half of the base length
                  note_in.duration_ms = {1'b0, quotient} +
                     (dotted_ff ? {2'b00, quotient[DIV_WIDTH-1:1]} : 19'd0);
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = note_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tempo_job_ff <= tempo_job_in;
      dotted_ff    <= dotted_in;
      note_ff      <= note_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/rtp_divider.sv]
// ----------------------------------------------------------------------------
// rtp_divider
// Bit-serial restoring divider: 18-bit dividend by 10-bit divisor, one
// quotient bit per cycle, done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module rtp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rtp_pkg::DIV_WIDTH-1:0]     dividend,
   input  logic [rtp_pkg::DIVISOR_WIDTH-1:0] divisor,
   output logic                              done,
   output logic [rtp_pkg::DIV_WIDTH-1:0]     quotient
);
   import rtp_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] div_ff, div_in;
   logic [DIV_WIDTH-1:0]     quo_ff, quo_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   // dividend bits shift out of the top of quo_ff as quotient bits shift in
   assign trial = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/rtp_parser.sv]
// ----------------------------------------------------------------------------
// rtp_parser
// Byte-level ringtone grammar: name skip, d/o/b header fields, note fields.
// Holds the song defaults and the pending note, and tells the sequencer
// what each request needs (whole-note division, note emit).
// ----------------------------------------------------------------------------
module rtp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rtp_pkg::rtp_req_type  req,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_wdata,
   input  logic                  wn_we,
   input  logic [17:0]           wn_value,
   output rtp_pkg::rtp_action_type act
);
   import rtp_pkg::*;

   localparam logic [3:0] PH_NAME     = 4'd0;
   localparam logic [3:0] PH_D_KEY    = 4'd1;
   localparam logic [3:0] PH_D_EQ     = 4'd2;
   localparam logic [3:0] PH_D_NUM    = 4'd3;
   localparam logic [3:0] PH_O_KEY    = 4'd4;
   localparam logic [3:0] PH_O_EQ     = 4'd5;
   localparam logic [3:0] PH_O_DIG    = 4'd6;
   localparam logic [3:0] PH_O_SEP    = 4'd7;
   localparam logic [3:0] PH_B_KEY    = 4'd8;
   localparam logic [3:0] PH_B_EQ     = 4'd9;
   localparam logic [3:0] PH_B_NUM    = 4'd10;
   localparam logic [3:0] PH_N_START  = 4'd11;
   localparam logic [3:0] PH_N_LETTER = 4'd12;
   localparam logic [3:0] PH_N_SHARP  = 4'd13;
   localparam logic [3:0] PH_N_DOT    = 4'd14;
   localparam logic [3:0] PH_N_OCT    = 4'd15;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;

   localparam logic signed [8:0] IDX_LIMIT = 9'(PITCH_TABLE_ENTRIES);
   localparam logic signed [8:0] TBL_LIMIT = 9'(PITCH_TABLE_SIZE);

   logic [3:0]  phase_ff, phase_in;
   logic [9:0]  acc_ff, acc_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [2:0]  doct_ff, doct_in;
   logic [9:0]  tempo_ff, tempo_in;
   logic [1:0]  shift_ff, shift_in;
   logic [17:0] wn_ff, wn_in;
   logic [7:0]  pdiv_ff, pdiv_in;
   logic [3:0]  pstep_ff, pstep_in;
   logic        pdot_ff, pdot_in;
   logic [3:0]  poct_ff, poct_in;
   logic        npend_ff, npend_in;

   logic [7:0]  c;
   logic        is_dig;
   logic        emit, last, note_valid, enter, start_note;
   logic [3:0]  letter_step;

   logic signed [5:0] oct_sum;
   logic signed [8:0] oct_ext;
   logic signed [8:0] idx;
   logic              rest;
   logic              bad;
   logic [7:0]        dv;

   function automatic logic [9:0] accum(input logic [9:0] a, input logic [3:0] d);
      logic [13:0] v;
      v = 14'({a, 3'b000}) + 14'({a, 1'b0}) + 14'(d);
      return (v > 14'd1023) ? 10'd1023 : v[9:0];
   endfunction

   function automatic logic [7:0] sat255(input logic [9:0] a);
      return (a > 10'd255) ? 8'd255 : a[7:0];
   endfunction

   assign c      = req.char_code;
   assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

   always_comb begin
      case (c)
         CH_C:    letter_step = 4'd1;
         CH_D:    letter_step = 4'd3;
         CH_E:    letter_step = 4'd5;
         CH_F:    letter_step = 4'd6;
         CH_G:    letter_step = 4'd8;
         CH_A:    letter_step = 4'd10;
         CH_B:    letter_step = 4'd12;
         default: letter_step = 4'd0;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      dlen_in    = dlen_ff;
      doct_in    = doct_ff;
      tempo_in   = tempo_ff;
      pdiv_in    = pdiv_ff;
      pstep_in   = pstep_ff;
      pdot_in    = pdot_ff;
      poct_in    = poct_ff;
      npend_in   = npend_ff;
      emit       = 1'b0;
      last       = 1'b0;
      note_valid = 1'b0;
      enter      = 1'b0;
      start_note = 1'b0;

      if (req.song_start) begin
         phase_in = PH_NAME;
         acc_in   = '0;
         npend_in = 1'b0;
      end

      if (c == CH_NUL) begin
         emit       = 1'b1;
         last       = 1'b1;
         note_valid = npend_in;
         npend_in   = 1'b0;
         phase_in   = PH_NAME;
         acc_in     = '0;
      end else begin
         case (phase_in)
            PH_NAME: begin
               if (c == CH_COLON) phase_in = PH_D_KEY;
            end
            PH_D_KEY, PH_O_KEY, PH_B_KEY: begin
               if (phase_in == PH_D_KEY && c == CH_D) begin
                  phase_in = PH_D_EQ;
               end else if (phase_in != PH_B_KEY && c == CH_O) begin
                  phase_in = PH_O_EQ;
               end else if (c == CH_B) begin
                  phase_in = PH_B_EQ;
               end else begin
                  enter      = 1'b1;
                  start_note = 1'b1;
               end
            end
            PH_D_EQ: begin
               acc_in   = '0;
               phase_in = PH_D_NUM;
            end
            PH_D_NUM: begin
               if (is_dig) begin
                  acc_in = accum(acc_ff, c[3:0]);
               end else begin
                  if (acc_ff != '0) dlen_in = sat255(acc_ff);
                  acc_in   = '0;
                  phase_in = PH_O_KEY;
               end
            end
            PH_O_EQ:  phase_in = PH_O_DIG;
            PH_O_DIG: begin
               if (c >= CH_THREE && c <= CH_SEVEN) doct_in = c[2:0];
               phase_in = PH_O_SEP;
            end
            PH_O_SEP: phase_in = PH_B_KEY;
            PH_B_EQ: begin
               acc_in   = '0;
               phase_in = PH_B_NUM;
            end
            PH_B_NUM: begin
               if (is_dig) begin
                  acc_in = accum(acc_ff, c[3:0]);
               end else begin
                  if (acc_ff != '0) tempo_in = acc_ff;
                  enter = 1'b1;
               end
            end
            PH_N_START: start_note = 1'b1;
            default: begin
               // note tail: sharp, dot, octave digit, else the note ends here
               if (c == CH_SHARP && phase_in == PH_N_LETTER) begin
                  pstep_in = pstep_ff + 1'b1;
                  phase_in = PH_N_SHARP;
               end else if (c == CH_DOT &&
                            (phase_in == PH_N_LETTER || phase_in == PH_N_SHARP)) begin
                  pdot_in  = 1'b1;
                  phase_in = PH_N_DOT;
               end else if (is_dig && phase_in != PH_N_OCT) begin
                  poct_in  = c[3:0];
                  phase_in = PH_N_OCT;
               end else begin
                  emit       = 1'b1;
                  note_valid = 1'b1;
                  npend_in   = 1'b0;
                  phase_in   = PH_N_START;
                  start_note = (c != CH_COMMA);
               end
            end
         endcase
      end

      if (enter) begin
         acc_in   = '0;
         phase_in = PH_N_START;
      end

      if (start_note) begin
         if (is_dig) begin
            acc_in = accum(acc_in, c[3:0]);
         end else begin
            pdiv_in  = sat255(acc_in);
            acc_in   = '0;
            pstep_in = letter_step;
            pdot_in  = 1'b0;
            poct_in  = {1'b0, doct_in};
            npend_in = 1'b1;
            phase_in = PH_N_LETTER;
         end
      end
   end

   // pitch and divisor of the note held before this request
   always_comb begin
      oct_sum = $signed({2'b00, poct_ff}) + $signed({{4{shift_ff[1]}}, shift_ff}) - 6'sd4;
      oct_ext = 9'(oct_sum);
      idx     = (oct_ext <<< 3) + (oct_ext <<< 2) + $signed({5'b00000, pstep_ff});
      rest    = (pstep_ff == 4'd0);
      bad     = !rest && ((idx < 9'sd1) || (idx >= IDX_LIMIT));
      dv      = (pdiv_ff != '0) ? pdiv_ff : dlen_ff;
      if (dv == '0) dv = 8'd1;

      act.emit          = emit;
      act.last          = last;
      act.note_valid    = note_valid;
      act.enter         = enter;
      act.dotted        = pdot_ff;
      act.is_rest       = note_valid ? rest : 1'b1;
      act.bad_pitch     = note_valid && bad;
      act.tone_hz       = '0;
      if (note_valid && !rest && !bad) begin
         act.tone_hz = (idx < TBL_LIMIT) ? pitch_lookup(idx[5:0]) : 12'hFFF;
      end
      act.note_divisor  = dv;
      act.tempo_divisor = (tempo_in == '0) ? 10'd1 : tempo_in;
      act.whole_note_ms = wn_ff;
   end

   always_comb begin
      shift_in = shift_ff;
      wn_in    = wn_ff;
      if (wn_we) wn_in = wn_value;
      if (csr_we) begin
         case (csr_index)
            CSR_OCT_SHIFT: shift_in = csr_wdata[1:0];
            default:       shift_in = shift_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         acc_ff   <= '0;
         dlen_ff  <= 8'd4;
         doct_ff  <= 3'd6;
         tempo_ff <= 10'd63;
         shift_ff <= 2'b11;
         wn_ff    <= '0;
         pdiv_ff  <= '0;
         pstep_ff <= '0;
         pdot_ff  <= 1'b0;
         poct_ff  <= '0;
         npend_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         wn_ff    <= wn_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INIT_LENGTH: dlen_ff  <= csr_wdata[7:0];
               CSR_INIT_OCTAVE: doct_ff  <= csr_wdata[2:0];
               CSR_INIT_TEMPO:  tempo_ff <= csr_wdata;
               default:         dlen_ff  <= dlen_ff;
            endcase
         end else if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            dlen_ff  <= dlen_in;
            doct_ff  <= doct_in;
            tempo_ff <= tempo_in;
            pdiv_ff  <= pdiv_in;
            pstep_ff <= pstep_in;
            pdot_ff  <= pdot_in;
            poct_ff  <= poct_in;
            npend_ff <= npend_in;
         end
      end
   end

endmodule

[hw/rtl/rtp_checker.sv]
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks for the ringtone parser, bound to the top level.
// ----------------------------------------------------------------------------
module rtp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input rtp_pkg::rtp_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rtp_pkg::rtp_rsp_type rsp_data
);
   import rtp_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a rest is silent and never flagged as a bad pitch
   a_rest_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_rest |-> rsp_data.tone_hz == 12'd0 && !rsp_data.bad_pitch)
      else $error("rest with tone or bad pitch");

   // a bad pitch plays nothing
   a_bad_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_pitch |-> rsp_data.tone_hz == 12'd0)
      else $error("bad pitch with nonzero tone");

   // end-of-song byte always leads to a response, so the parser goes busy
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.char_code == 8'h00 |=> req_stall)
      else $error("end-of-song request did not start a response");

endmodule

bind rtttl_ringtone_parser rtp_checker u_rtp_checker (.*);

[tb/sv/rtttl_ringtone_parser_test.sv]
// ----------------------------------------------------------------------------
// rtttl_ringtone_parser_test
// Self-checking bench for the ringtone parser. A queue of string bytes feeds
// a driver; every accepted byte runs through a local parser model that
// predicts the note it completes, and a monitor compares each response with
// the oldest predicted note. Random songs, header fields and noise are sent
// under several register settings, with random idle and stall bursts in most.
// ----------------------------------------------------------------------------
module rtttl_ringtone_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rtp_pkg::*;

   typedef enum logic [3:0] {
      SKIP_NAME, LEN_KEY, LEN_EQ, LEN_NUM, OCT_KEY, OCT_EQ, OCT_DIG, OCT_SEP,
      BPM_KEY, BPM_EQ, BPM_NUM, NOTE_START, NOTE_LETTER, NOTE_SHARP, NOTE_DOT,
      NOTE_OCT
   } grammar_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rtp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rtp_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   rtttl_ringtone_parser uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [11:0] pitch_hz [0:48] = '{12'd0,
      12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349,
      12'd370, 12'd392, 12'd415, 12'd440, 12'd466, 12'd494,
      12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698,
      12'd740, 12'd784, 12'd831, 12'd880, 12'd932, 12'd988,
      12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
      12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
      12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
      12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951};

   // parser model state
   grammar_phase_type phase = SKIP_NAME;
   logic [9:0]        num_acc = '0;
   logic [7:0]        dflt_len = 8'd4;
   logic [2:0]        dflt_oct = 3'd6;
   logic [9:0]        tempo = 10'd63;
   logic signed [1:0] oct_shift = -2'sd1;
   logic [17:0]       whole_ms = '0;
   logic [7:0]        pend_div = '0;
   logic [3:0]        pend_step = '0;
   logic              pend_dot = 1'b0;
   logic [3:0]        pend_oct = '0;
   logic              pend_valid = 1'b0;

   rtp_req_type byte_queue [$];
   rtp_rsp_type expected_notes [$];
   rtp_rsp_type want_note, next_note;
   string       note_letters = "cdefgabp";
   bit          idling_on = 1'b1;
   int          gap_left = 0;
   int          stall_left = 0;
   int          bytes_sent = 0;
   int          notes_checked = 0;
   int          songs_ended = 0;
   int          settings_used = 1;
   int          failures = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void add_digit(input logic [7:0] c);
      int v;
      v = int'(num_acc) * 10 + int'(c) - 48;
      num_acc = v > 1023 ? 10'd1023 : 10'(v);
   endfunction

   function automatic void start_notes();
      int unsigned t;
      t = tempo != 0 ? tempo : 1;
      whole_ms = 18'((60000 / t) * 4);
      num_acc = '0;
      phase = NOTE_START;
   endfunction

   function automatic void begin_note(input logic [7:0] c);
      if (is_digit(c)) begin
         add_digit(c);
      end else begin
         pend_div = num_acc > 255 ? 8'd255 : num_acc[7:0];
         num_acc = '0;
         case (c)
            "c": pend_step = 4'd1;
            "d": pend_step = 4'd3;
            "e": pend_step = 4'd5;
            "f": pend_step = 4'd6;
            "g": pend_step = 4'd8;
            "a": pend_step = 4'd10;
            "b": pend_step = 4'd12;
            default: pend_step = 4'd0;
         endcase
         pend_dot = 1'b0;
         pend_oct = {1'b0, dflt_oct};
         pend_valid = 1'b1;
         phase = NOTE_LETTER;
      end
   endfunction

   function automatic rtp_rsp_type make_note(input bit real_note, input bit end_flag);
      rtp_rsp_type n;
      int unsigned divisor, dur;
      int idx;
      n = '0;
      n.is_rest = 1'b1;
      if (real_note) begin
         divisor = pend_div != 0 ? pend_div : dflt_len;
         if (divisor == 0) divisor = 1;
         dur = whole_ms / divisor;
         if (pend_dot) dur = dur + dur / 2;
         idx = (int'(pend_oct) + int'(oct_shift) - 4) * 12 + int'(pend_step);
         n.duration_ms = 19'(dur);
         n.is_rest = pend_step == 0;
         if (!n.is_rest) begin
            if (idx < 1 || idx >= int'(PITCH_TABLE_ENTRIES)) n.bad_pitch = 1'b1;
            else n.tone_hz = idx < 49 ? pitch_hz[idx] : 12'd4095;
         end
      end
      n.last = end_flag;
      pend_valid = 1'b0;
      return n;
   endfunction

   // advances the model by one byte, returns 1 when the byte completes a note or ends the song
   function automatic bit parse_byte(input rtp_req_type r, output rtp_rsp_type note);
      logic [7:0] c;
      c = r.char_code;
      note = '0;
      if (r.song_start) begin
         phase = SKIP_NAME;
         num_acc = '0;
         pend_valid = 1'b0;
      end
      if (c == 8'd0) begin
         note = make_note(pend_valid, 1'b1);
         phase = SKIP_NAME;
         num_acc = '0;
         return 1'b1;
      end
      case (phase)
         SKIP_NAME: if (c == ":") phase = LEN_KEY;
         LEN_KEY, OCT_KEY, BPM_KEY: begin
            // a missing key falls through to the later ones
            if (phase == LEN_KEY && c == "d") phase = LEN_EQ;
            else if (phase != BPM_KEY && c == "o") phase = OCT_EQ;
            else if (c == "b") phase = BPM_EQ;
            else begin
               start_notes();
               begin_note(c);
            end
         end
         LEN_EQ: begin
            num_acc = '0;
            phase = LEN_NUM;
         end
         LEN_NUM: begin
            if (is_digit(c)) begin
               add_digit(c);
            end else begin
               if (num_acc > 0) dflt_len = num_acc > 255 ? 8'd255 : num_acc[7:0];
               num_acc = '0;
               phase = OCT_KEY;
            end
         end
         OCT_EQ: phase = OCT_DIG;
         OCT_DIG: begin
            if (c >= "3" && c <= "7") dflt_oct = 3'(c - "0");
            phase = OCT_SEP;
         end
         OCT_SEP: phase = BPM_KEY;
         BPM_EQ: begin
            num_acc = '0;
            phase = BPM_NUM;
         end
         BPM_NUM: begin
            if (is_digit(c)) begin
               add_digit(c);
            end else begin
               if (num_acc > 0) tempo = num_acc;
               start_notes();
            end
         end
         NOTE_START: begin_note(c);
         default: begin
            if (c == "#" && phase == NOTE_LETTER) begin
               pend_step = pend_step + 4'd1;
               phase = NOTE_SHARP;
            end else if (c == "." && (phase == NOTE_LETTER || phase == NOTE_SHARP)) begin
               pend_dot = 1'b1;
               phase = NOTE_DOT;
            end else if (is_digit(c) && phase != NOTE_OCT) begin
               pend_oct = 4'(c - "0");
               phase = NOTE_OCT;
            end else begin
               note = make_note(1'b1, 1'b0);
               phase = NOTE_START;
               if (c != ",") begin_note(c);
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_byte(req_data, next_note)) expected_notes.push_back(next_note);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               req_data <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               $display("%0t: note with none expected, expected nothing, actual %p",
                        $time, rsp_data);
               failures++;
            end else begin
               want_note = expected_notes.pop_front();
               compare_field("tone_hz", want_note.tone_hz, rsp_data.tone_hz);
               compare_field("duration_ms", want_note.duration_ms, rsp_data.duration_ms);
               compare_field("is_rest", want_note.is_rest, rsp_data.is_rest);
               compare_field("bad_pitch", want_note.bad_pitch, rsp_data.bad_pitch);
               compare_field("last", want_note.last, rsp_data.last);
               notes_checked++;
               if (rsp_data.last) songs_ended++;
            end
         end
         if (stall_left != 0) stall_left--;
         else if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
         rsp_stall <= stall_left != 0;
      end
   end

   task automatic push_byte(input logic [7:0] c, input bit start);
      byte_queue.push_back({c, start});
   endtask

   task automatic push_text(input string s, input bit start);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], start && i == 0);
   endtask

   function automatic int unsigned pick_number();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 99999);
         2, 3: return 1 << $urandom_range(0, 5);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   task automatic push_song();
      int name_len, note_count;
      logic [7:0] c;
      name_len = $urandom_range(0, 6);
      for (int i = 0; i < name_len; i++) begin
         c = $urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                       : 8'($urandom_range(97, 122));
         if (c == ":") c = "x";
         push_byte(c, i == 0);
      end
      push_byte(":", name_len == 0);
      if ($urandom_range(0, 3) != 0) begin
         push_text("d=", 0);
         push_text($sformatf("%0d", pick_number()), 0);
         push_byte(",", 0);
      end
      if ($urandom_range(0, 3) != 0) begin
         push_text("o=", 0);
         push_byte($urandom_range(0, 3) != 0 ? 8'($urandom_range(51, 55))
                                             : 8'($urandom_range(1, 255)), 0);
         push_byte(",", 0);
      end
      if ($urandom_range(0, 3) != 0) begin
         push_text("b=", 0);
         push_text($sformatf("%0d", $urandom_range(0, 3) == 0 ? pick_number()
                                                             : $urandom_range(20, 300)), 0);
         push_byte(":", 0);
      end else if ($urandom_range(0, 1) == 0) begin
         push_byte(":", 0);
      end
      note_count = $urandom_range(1, 8);
      for (int i = 0; i < note_count; i++) begin
         if ($urandom_range(0, 1) == 0) push_text($sformatf("%0d", pick_number()), 0);
         push_byte($urandom_range(0, 7) != 0 ? note_letters[$urandom_range(0, 7)]
                                             : 8'($urandom_range(1, 255)), 0);
         if ($urandom_range(0, 3) == 0) push_byte("#", 0);
         if ($urandom_range(0, 3) == 0) push_byte(".", 0);
         if ($urandom_range(0, 1) == 0)
            push_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(48, 57))
                                                : 8'($urandom_range(52, 55)), 0);
         if (i < note_count - 1 || $urandom_range(0, 1) == 0) push_byte(",", 0);
      end
      // stray length digits before the end are dropped, though one may become an octave
      if ($urandom_range(0, 7) == 0) push_text($sformatf("%0d", $urandom_range(0, 999)), 0);
      if ($urandom_range(0, 7) != 0) push_byte(8'd0, $urandom_range(0, 15) == 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [9:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_INIT_LENGTH: dflt_len = val[7:0];
         CSR_INIT_OCTAVE: dflt_oct = val[2:0];
         CSR_INIT_TEMPO:  tempo = val;
         CSR_OCT_SHIFT:   oct_shift = val[1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input int len, input int oct, input int bpm, input int shift);
      write_csr(CSR_INIT_LENGTH, 10'(len));
      write_csr(CSR_INIT_OCTAVE, 10'(oct));
      write_csr(CSR_INIT_TEMPO, 10'(bpm));
      write_csr(CSR_OCT_SHIFT, 10'(shift & 3));
      settings_used++;
   endtask

   // wait until every request is taken and every note seen, then let the
   // divider finish any header end that yields no note
   task automatic drain();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || expected_notes.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extreme header values, high sharp with bad pitch, sharp pause,
      // end with and without a pending note, noise on a song start
      push_text(":d=1,o=3,b=1:b#.9,p#,c", 1);
      push_byte(8'd0, 0);
      push_byte(8'd0, 0);
      push_byte(8'hFF, 1);
      drain();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: set_config(1, 3, 1, -2);
            1: set_config(255, 7, 1023, 1);
            2: set_config(4, 6, 63, -1);
            default: set_config($urandom_range(1, 255), $urandom_range(3, 7),
                                $urandom_range(1, 1023), $urandom_range(0, 3));
         endcase
         idling_on = p < 6;
         target = byte_queue.size() + 65;
         while (byte_queue.size() < target) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 5))
                  push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
               push_song();
            end
         end
         drain();
      end

      $display("summary: %0d bytes under %0d register settings", bytes_sent, settings_used);
      $display("summary: %0d notes checked, %0d songs ended", notes_checked, songs_ended);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_divider.sv
hw/rtl/rtp_parser.sv
hw/rtl/rtttl_ringtone_parser.sv
hw/rtl/rtp_checker.sv
tb/sv/rtttl_ringtone_parser_test.sv
